// ----- hw/rtl/integer_field_formatter_core_defines.svh -----
// Assertion macros shared by the integer field formatter RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IFMT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ifmt: same-cycle check failed");
// next-cycle implication
`define IFMT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ifmt: next-cycle check failed");
`else
`define IFMT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IFMT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/ifmt_pkg.sv -----
// Shared types and constants for the integer field formatter.
// No dependencies.
package ifmt_pkg;

   localparam int MAG_W             = 64;
   localparam int FIELD_W_W         = 7;
   localparam int DIGIT_W           = 4;
   localparam int NUM_DIGITS        = 20;   // 2^64-1 has 20 decimal digits
   localparam int BITS_PER_CELL     = 4;
   localparam int NUM_CELLS         = MAG_W / BITS_PER_CELL;
   localparam int MAX_CONTENT       = NUM_DIGITS + 3;  // sign + "0x" + digits
   localparam int DEFAULT_MAX_WIDTH = 64;

   typedef enum logic {
      OP_DEC = 1'b0,
      OP_HEX = 1'b1
   } ifmt_op_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;

   localparam logic [7:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] ifmt_digits_type;

   // One request in flight along the conversion row.
   typedef struct packed {
      ifmt_digits_type        digits;
      logic [MAG_W-1:0]       bin;
      ifmt_op_type            opcode;
      logic                   negative;
      logic [FIELD_W_W-1:0]   field_width;   // already saturated
      logic                   zero_fill;
      logic                   left_align;
      logic                   hex_prefix;
   } ifmt_item_type;

endpackage

// ----- hw/rtl/ifmt_cell.sv -----
// One conversion cell: shifts BITS_PER_CELL magnitude bits into the digit
// register (add-3 correction in decimal). Depends on ifmt_pkg.
module ifmt_cell import ifmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  ifmt_item_type up_item,
   output logic          up_ready,
   output logic          down_valid,
   output ifmt_item_type down_item,
   input  logic          down_ready
);

   logic          valid_ff;
   logic          valid_in;
   ifmt_item_type item_ff;
   ifmt_item_type item_in;

   function automatic ifmt_item_type cell_step(input ifmt_item_type it);
      ifmt_item_type r;
      r = it;
      for (int b = 0; b < BITS_PER_CELL; b++) begin
         if (r.opcode == OP_DEC) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
               if (r.digits[d] >= 4'd5) begin
                  r.digits[d] = r.digits[d] + 4'd3;
               end
            end
         end
         {r.digits, r.bin} = {r.digits, r.bin} << 1;
      end
      return r;
   endfunction

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (up_ready) begin
         valid_in = up_valid;
         if (up_valid) begin
            item_in = cell_step(up_item);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- hw/rtl/ifmt_emit.sv -----
// Character emitter (depends on ifmt_pkg): lays out padding, sign, prefix and
// digits of a converted request; one character per cycle unless stalled.
`include "integer_field_formatter_core_defines.svh"
module ifmt_emit import ifmt_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          tail_valid,
   input  ifmt_item_type tail_item,
   output logic          tail_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_char,
   output logic          rsp_last
);

   localparam int MaxLen    = (MAX_WIDTH > MAX_CONTENT) ? MAX_WIDTH : MAX_CONTENT;
   localparam int CNT_W     = $clog2(MaxLen + 1);
   localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);
   localparam int DIG_IDX_W = $clog2(NUM_DIGITS);

   function automatic logic [DIG_CNT_W-1:0] sig_digits(input ifmt_digits_type dg);
      logic [DIG_CNT_W-1:0] n;
      n = DIG_CNT_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (dg[i] != '0) begin
            n = DIG_CNT_W'(i + 1);
         end
      end
      return n;
   endfunction

   logic                 busy_ff,      busy_in;
   logic [CNT_W-1:0]     pos_ff,       pos_in;
   logic [CNT_W-1:0]     end_lead_ff,  end_lead_in;
   logic [CNT_W-1:0]     end_sign_ff,  end_sign_in;
   logic [CNT_W-1:0]     end_pfx_ff,   end_pfx_in;
   logic [CNT_W-1:0]     end_zpad_ff,  end_zpad_in;
   logic [CNT_W-1:0]     end_dig_ff,   end_dig_in;
   logic [CNT_W-1:0]     total_ff,     total_in;
   ifmt_digits_type      digits_ff,    digits_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff,  rsp_char_in;
   logic                 rsp_last_ff,  rsp_last_in;

   logic                 emit;
   logic                 is_last;
   logic                 load;
   logic [7:0]           cur_char;
   logic [DIG_IDX_W-1:0] dig_idx;
   logic [CNT_W-1:0]     ld_nd, ld_content, ld_width, ld_pad;
   logic [CNT_W-1:0]     ld_lead, ld_zpad, ld_trail;

   // layout of the next request
   always_comb begin
      ld_nd      = CNT_W'(sig_digits(tail_item.digits));
      ld_content = ld_nd + CNT_W'(tail_item.negative)
                   + (tail_item.hex_prefix ? CNT_W'(2) : CNT_W'(0));
      ld_width   = CNT_W'(tail_item.field_width);
      ld_pad     = (ld_width > ld_content) ? (ld_width - ld_content) : '0;
      ld_lead    = (!tail_item.left_align && !tail_item.zero_fill) ? ld_pad : '0;
      ld_zpad    = (!tail_item.left_align && tail_item.zero_fill) ? ld_pad : '0;
      ld_trail   = tail_item.left_align ? ld_pad : '0;
      end_lead_in = ld_lead;
      end_sign_in = end_lead_in + CNT_W'(tail_item.negative);
      end_pfx_in  = end_sign_in + (tail_item.hex_prefix ? CNT_W'(2) : CNT_W'(0));
      end_zpad_in = end_pfx_in + ld_zpad;
      end_dig_in  = end_zpad_in + ld_nd;
      total_in    = end_dig_in + ld_trail;
      digits_in   = tail_item.digits;
   end

   // character at the current position
   always_comb begin
      dig_idx = DIG_IDX_W'(end_dig_ff - pos_ff - CNT_W'(1));
      priority if (pos_ff < end_lead_ff) begin
         cur_char = CH_SPACE;
      end else if (pos_ff < end_sign_ff) begin
         cur_char = CH_MINUS;
      end else if (pos_ff < end_pfx_ff) begin
         cur_char = (pos_ff == end_sign_ff) ? CH_ZERO : CH_X;
      end else if (pos_ff < end_zpad_ff) begin
         cur_char = CH_ZERO;
      end else if (pos_ff < end_dig_ff) begin
         cur_char = DIGIT_CHARS[digits_ff[dig_idx]];
      end else begin
         cur_char = CH_SPACE;
      end
   end

   assign emit       = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last    = (pos_ff == total_ff - CNT_W'(1));
   assign tail_ready = !busy_ff || (emit && is_last);
   assign load       = tail_valid && tail_ready;

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = cur_char;
         rsp_last_in  = is_last;
         pos_in       = pos_ff + CNT_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (load) begin
         end_lead_ff <= end_lead_in;
         end_sign_ff <= end_sign_in;
         end_pfx_ff  <= end_pfx_in;
         end_zpad_ff <= end_zpad_in;
         end_dig_ff  <= end_dig_in;
         total_ff    <= total_in;
         digits_ff   <= digits_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   `IFMT_ASSERT_IMP(a_pos_in_field, clock, reset, busy_ff, pos_ff < total_ff)
   `IFMT_ASSERT_IMP(a_has_digit, clock, reset, busy_ff, end_dig_ff > end_zpad_ff)
   `IFMT_ASSERT_NXT(a_idle_after_last, clock, reset, emit && is_last && !tail_valid, !busy_ff)

endmodule

// ----- hw/rtl/integer_field_formatter_core.sv -----
// Top level of the integer field formatter: conversion row plus emitter.
// Depends on ifmt_pkg, ifmt_cell and ifmt_emit.
//
// Formats one printf-style integer field per request and returns it as ASCII
// characters, one per response, with rsp_last on the final one. A request
// enters a row of NUM_CELLS (16) identical conversion cells, each shifting
// four magnitude bits into a 20-digit register (double dabble for decimal,
// plain shift for hex), so up to 16 requests can be converting at once.
// The emitter then sends one character per cycle while rsp_ready is high;
// a field is max(width, content) characters long, 1 to 64, and the emitter
// loads the next field in the cycle that it sends the previous field's last
// character. Sustained rate is therefore one character per cycle while
// rsp_ready stays high, set by the single-character output port. Widths
// above MAX_WIDTH are clamped on entry. The result register holds each
// character until it is taken; rsp_ready still reaches req_ready
// combinationally through the emitter and the ready chain of the cells.
module integer_field_formatter_core import ifmt_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MAG_W-1:0]     req_magnitude,
   input  logic                 req_negative,
   input  logic                 req_opcode,
   input  logic [FIELD_W_W-1:0] req_field_width,
   input  logic                 req_zero_fill,
   input  logic                 req_left_align,
   input  logic                 req_hex_prefix,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_last
);

   localparam logic [FIELD_W_W-1:0] WidthCap = FIELD_W_W'(MAX_WIDTH);

   // link k feeds cell k; link NUM_CELLS feeds the emitter
   logic [NUM_CELLS:0] link_valid;
   logic [NUM_CELLS:0] link_ready;
   ifmt_item_type      link_item [NUM_CELLS+1];

   always_comb begin
      link_item[0]             = '0;
      link_item[0].bin         = req_magnitude;
      link_item[0].opcode      = ifmt_op_type'(req_opcode);
      link_item[0].negative    = req_negative;
      link_item[0].field_width = (req_field_width > WidthCap) ? WidthCap : req_field_width;
      link_item[0].zero_fill   = req_zero_fill;
      link_item[0].left_align  = req_left_align;
      link_item[0].hex_prefix  = req_hex_prefix;
   end

   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_row
      ifmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[k]),
         .up_item    (link_item[k]),
         .up_ready   (link_ready[k]),
         .down_valid (link_valid[k+1]),
         .down_item  (link_item[k+1]),
         .down_ready (link_ready[k+1])
      );
   end

   ifmt_emit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .tail_valid   (link_valid[NUM_CELLS]),
      .tail_item    (link_item[NUM_CELLS]),
      .tail_ready   (link_ready[NUM_CELLS]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule
